// ----- src/pwm_pkg.sv -----
`default_nettype none
package pwm_pkg;

  // Destination frame
  localparam int DEST_WIDTH  = 640;
  localparam int DEST_HEIGHT = 480;

  // Field widths
  localparam int XW   = 11;
  localparam int PIXW = 24;
  localparam int DXW  = 10;
  localparam int DYW  = 9;
  localparam int CW   = 32;

  // Internal widths: products, sums, shifted numerator, quotient bits
  localparam int PW = CW + XW + 1;
  localparam int SW = PW + 2;
  localparam int MW = SW + 14;
  localparam int QW = 12;
  localparam int LW = QW + 1;

  localparam logic [LW-1:0] LIM_X = LW'(DEST_WIDTH);
  localparam logic [LW-1:0] LIM_Y = LW'(DEST_HEIGHT);
  localparam logic signed [SW-1:0] ONE_Q30 = SW'(64'd1 << 30);

  // Register indexes
  localparam logic [2:0] REG_ENABLE = 3'd0;
  localparam logic [2:0] REG_A      = 3'd1;
  localparam logic [2:0] REG_B      = 3'd2;
  localparam logic [2:0] REG_C      = 3'd3;
  localparam logic [2:0] REG_D      = 3'd4;
  localparam logic [2:0] REG_E      = 3'd5;
  localparam logic [2:0] REG_F      = 3'd6;
  localparam logic [2:0] REG_PERSP  = 3'd7;

  // One word inside the divider pipeline
  typedef struct packed {
    logic            keep;
    logic            neg_x;
    logic            neg_y;
    logic [SW-1:0]   dmag;
    logic [MW-1:0]   rem_x;
    logic [MW-1:0]   rem_y;
    logic [QW-1:0]   q_x;
    logic [QW-1:0]   q_y;
    logic [PIXW-1:0] pix;
  } div_t;

endpackage
`default_nettype wire

// ----- src/perspective_warp_pixel_mapper.sv -----
`default_nettype none
// Maps each source pixel through a planar homography held in registers
// 1..7 (register 0 enables the warp) and passes it on at its destination coordinate, or drops it when the
// warp is off, the denominator is zero or the point falls outside the frame.
// One pixel enters per clock while the output is not stalled; the pipeline has one
// multiply stage, one sum stage, one magnitude stage, one range check stage, twelve restoring
// divide stages (one quotient bit each) and the output register. A stall on
// the output freezes the whole pipeline.
module perspective_warp_pixel_mapper (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        in_valid_i,
  output logic                             in_stall_o,
  input  wire logic [pwm_pkg::XW-1:0]      in_x_i,
  input  wire logic [pwm_pkg::XW-1:0]      in_y_i,
  input  wire logic [pwm_pkg::PIXW-1:0]    in_pixel_i,
  output logic                             out_valid_o,
  input  wire logic                        out_stall_i,
  output logic [pwm_pkg::DXW-1:0]          dest_x_o,
  output logic [pwm_pkg::DYW-1:0]          dest_y_o,
  output logic [pwm_pkg::PIXW-1:0]         out_pixel_o,
  input  wire logic                        cfg_valid_i,
  output logic                             cfg_ready_o,
  input  wire logic [2:0]                  cfg_index_i,
  input  wire logic [63:0]                 cfg_data_i
);

  localparam int PW = pwm_pkg::PW;
  localparam int SW = pwm_pkg::SW;
  localparam int MW = pwm_pkg::MW;
  localparam int QW = pwm_pkg::QW;

  // Configuration registers
  logic                 en_q;
  logic signed [31:0]   a_q, b_q, c_q, d_q, e_q, f_q, g_q, h_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      en_q <= 1'b0;
      a_q  <= 32'sd65536;
      b_q  <= '0;
      c_q  <= '0;
      d_q  <= '0;
      e_q  <= 32'sd65536;
      f_q  <= '0;
      g_q  <= '0;
      h_q  <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        pwm_pkg::REG_ENABLE: en_q <= cfg_data_i[0];
        pwm_pkg::REG_A:      a_q  <= cfg_data_i[31:0];
        pwm_pkg::REG_B:      b_q  <= cfg_data_i[31:0];
        pwm_pkg::REG_C:      c_q  <= cfg_data_i[31:0];
        pwm_pkg::REG_D:      d_q  <= cfg_data_i[31:0];
        pwm_pkg::REG_E:      e_q  <= cfg_data_i[31:0];
        pwm_pkg::REG_F:      f_q  <= cfg_data_i[31:0];
        pwm_pkg::REG_PERSP: begin
          g_q <= cfg_data_i[31:0];
          h_q <= cfg_data_i[63:32];
        end
        default: ;
      endcase
    end
  end

  // Advance everything unless the output word is held
  logic adv;
  assign adv        = !(out_valid_o && out_stall_i);
  assign in_stall_o = !adv;

  // Stage 1: products
  logic               s1_v_q, s1_en_q;
  logic signed [PW-1:0] gx_q, hy_q, ax_q, by_q, dx_q, ey_q;
  logic [pwm_pkg::PIXW-1:0] s1_pix_q;
  logic signed [pwm_pkg::XW:0] xs, ys;
  assign xs = signed'({1'b0, in_x_i});
  assign ys = signed'({1'b0, in_y_i});

  // Stage 2: sums
  logic               s2_v_q, s2_en_q;
  logic signed [SW-1:0] den_q, nx_q, ny_q;
  logic [pwm_pkg::PIXW-1:0] s2_pix_q;

  // Stage 3: magnitudes and signs
  logic               s3_v_q, s3_keep_q, s3_negx_q, s3_negy_q;
  logic [SW-1:0]      s3_dmag_q;
  logic [MW-1:0]      s3_mx_q, s3_my_q;
  logic [pwm_pkg::PIXW-1:0] s3_pix_q;
  logic [SW-1:0]      nxm_d, nym_d, dm_d;
  assign nxm_d = nx_q[SW-1] ? SW'(-nx_q) : SW'(nx_q);
  assign nym_d = ny_q[SW-1] ? SW'(-ny_q) : SW'(ny_q);
  assign dm_d  = den_q[SW-1] ? SW'(-den_q) : SW'(den_q);

  // Stage 4: frame limit check, quotient >= L iff M >= L*|D|
  logic [MW-1:0] limx_d, limy_d;
  assign limx_d = MW'(s3_dmag_q) * MW'(pwm_pkg::LIM_X);
  assign limy_d = MW'(s3_dmag_q) * MW'(pwm_pkg::LIM_Y);
  pwm_pkg::div_t div0_d;
  always_comb begin
    div0_d       = '0;
    div0_d.keep  = s3_keep_q && (s3_mx_q < limx_d) && (s3_my_q < limy_d);
    div0_d.neg_x = s3_negx_q;
    div0_d.neg_y = s3_negy_q;
    div0_d.dmag  = s3_dmag_q;
    div0_d.rem_x = s3_mx_q;
    div0_d.rem_y = s3_my_q;
    div0_d.pix   = s3_pix_q;
  end

  logic [QW:0]          dv_q;
  pwm_pkg::div_t        dw_q [QW+1];
  pwm_pkg::div_t        dw_d [QW];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      dv_q   <= '0;
    end else if (adv) begin
      s1_v_q <= in_valid_i;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      dv_q   <= {dv_q[QW-1:0], s3_v_q};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_en_q  <= en_q;
      gx_q     <= g_q * xs;
      hy_q     <= h_q * ys;
      ax_q     <= a_q * xs;
      by_q     <= b_q * ys;
      dx_q     <= d_q * xs;
      ey_q     <= e_q * ys;
      s1_pix_q <= in_pixel_i;

      s2_en_q  <= s1_en_q;
      den_q    <= SW'(gx_q) + SW'(hy_q) + pwm_pkg::ONE_Q30;
      nx_q     <= SW'(ax_q) + SW'(by_q) + SW'(c_q);
      ny_q     <= SW'(dx_q) + SW'(ey_q) + SW'(f_q);
      s2_pix_q <= s1_pix_q;

      s3_keep_q <= s2_en_q && (den_q != '0);
      s3_negx_q <= nx_q[SW-1] != den_q[SW-1];
      s3_negy_q <= ny_q[SW-1] != den_q[SW-1];
      s3_dmag_q <= dm_d;
      s3_mx_q   <= MW'(nxm_d) << 14;
      s3_my_q   <= MW'(nym_d) << 14;
      s3_pix_q  <= s2_pix_q;

      dw_q[0] <= div0_d;
      for (int k = 0; k < QW; k++) begin
        dw_q[k+1] <= dw_d[k];
      end
    end
  end

  // Stages 5..16: one restoring divide step per stage, MSB first
  for (genvar k = 0; k < QW; k++) begin : g_div
    localparam int B = QW - 1 - k;
    logic [MW-1:0] sub;
    assign sub = MW'(dw_q[k].dmag) << B;
    always_comb begin
      dw_d[k] = dw_q[k];
      if (dw_q[k].rem_x >= sub) begin
        dw_d[k].rem_x  = dw_q[k].rem_x - sub;
        dw_d[k].q_x[B] = 1'b1;
      end
      if (dw_q[k].rem_y >= sub) begin
        dw_d[k].rem_y  = dw_q[k].rem_y - sub;
        dw_d[k].q_y[B] = 1'b1;
      end
    end
  end

  // Output register; a negative nonzero quotient lies left of or above the frame
  logic ok_d;
  assign ok_d = dw_q[QW].keep
             && !(dw_q[QW].neg_x && (dw_q[QW].q_x != '0))
             && !(dw_q[QW].neg_y && (dw_q[QW].q_y != '0));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= dv_q[QW] && ok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      dest_x_o    <= dw_q[QW].q_x[pwm_pkg::DXW-1:0];
      dest_y_o    <= dw_q[QW].q_y[pwm_pkg::DYW-1:0];
      out_pixel_o <= dw_q[QW].pix;
    end
  end

endmodule
`default_nettype wire

// ----- src/pwm_checker.sv -----
`default_nettype none
module pwm_checker (
  input wire logic                     clk_i,
  input wire logic                     rst_ni,
  input wire logic                     in_stall_o,
  input wire logic                     out_valid_o,
  input wire logic                     out_stall_i,
  input wire logic [pwm_pkg::DXW-1:0]  dest_x_o,
  input wire logic [pwm_pkg::DYW-1:0]  dest_y_o,
  input wire logic [pwm_pkg::PIXW-1:0] out_pixel_o
);

  // A held output word stays put
  a_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output word dropped while stalled");

  a_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(dest_x_o) && $stable(dest_y_o)
      && $stable(out_pixel_o))
    else $error("output word changed while stalled");

  // Input backpressure comes only from a held output word
  a_stall_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i)
    else $error("input stalled without output backpressure");

  // Every emitted coordinate lies inside the frame
  a_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (32'(dest_x_o) < pwm_pkg::DEST_WIDTH)
      && (32'(dest_y_o) < pwm_pkg::DEST_HEIGHT))
    else $error("destination outside frame");

endmodule

bind perspective_warp_pixel_mapper pwm_checker u_pwm_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .dest_x_o    (dest_x_o),
  .dest_y_o    (dest_y_o),
  .out_pixel_o (out_pixel_o)
);
`default_nettype wire
